// ===== src/stim_artifact_window_repair_core_assert.svh =====
// Assertion macros for the artifact window repair core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef STIM_ARTIFACT_WINDOW_REPAIR_CORE_ASSERT_SVH
`define STIM_ARTIFACT_WINDOW_REPAIR_CORE_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define SAWR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define SAWR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/sawr_pkg.sv =====
// Shared types and codes for the artifact window repair core.
// No dependencies.
package sawr_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FILTERED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [1:0] K_WRITE  = 2'd0;
    localparam logic [1:0] K_READ   = 2'd1;
    localparam logic [1:0] K_EVENT  = 2'd2;
    localparam logic [1:0] K_STATUS = 2'd3;

    localparam logic [2:0] REG_START_OFFSET = 3'd0;
    localparam logic [2:0] REG_END_OFFSET   = 3'd1;
    localparam logic [2:0] REG_CODE_FILTER  = 3'd2;
    localparam logic [2:0] REG_REPAIR_MODE  = 3'd3;
    localparam logic [2:0] REG_CHANNELS     = 3'd4;
    localparam logic [2:0] REG_SAMPLES      = 3'd5;

    typedef struct packed {
        logic signed [13:0] start_offset;
        logic signed [13:0] end_offset;
        logic signed [16:0] code_filter;
        logic               repair_mode;
        logic [4:0]         channels;
        logic [12:0]        samples;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic [3:0]         channel;
        logic [11:0]        sample_index;
        logic signed [23:0] sample_value;
        logic [12:0]        win_start;
        logic [12:0]        win_end;
    } t_item;

    typedef struct packed {
        logic pop;
        logic res_load;
        logic busy;
    } t_back_stat;

endpackage

// ===== src/sawr_front.sv =====
// Front part: classifies accepted commands and computes clamped event windows.
// Depends on sawr_pkg.
module sawr_front import sawr_pkg::*; (
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_channel,
    input  logic [11:0]        i_sample_index,
    input  logic signed [23:0] i_sample_value,
    input  logic [15:0]        i_event_position,
    input  logic [15:0]        i_event_code,
    input  t_cfg               i_cfg,
    output t_item              o_item
);

    logic signed [17:0] w_ws;
    logic signed [17:0] w_we;
    logic signed [17:0] w_ws_c;
    logic signed [17:0] w_we_c;
    logic signed [17:0] w_last;
    logic               w_filtered;
    logic               w_range;

    always_comb begin
        w_ws   = $signed({2'b00, i_event_position}) + 18'(i_cfg.start_offset);
        w_we   = $signed({2'b00, i_event_position}) + 18'(i_cfg.end_offset);
        w_last = $signed({5'd0, i_cfg.samples}) - 18'sd1;
        w_ws_c = (w_ws < 18'sd0) ? 18'sd0 : w_ws;
        w_we_c = (w_we > w_last) ? w_last : w_we;
        w_filtered = !i_cfg.code_filter[16] && ($signed({1'b0, i_event_code}) != i_cfg.code_filter);
        w_range = ({1'b0, i_channel} >= i_cfg.channels) || ({1'b0, i_sample_index} >= i_cfg.samples);

        o_item.channel      = i_channel;
        o_item.sample_index = i_sample_index;
        o_item.sample_value = i_sample_value;
        o_item.win_start    = w_ws_c[12:0];
        o_item.win_end      = w_we_c[12:0];
        o_item.status       = ST_DONE;
        o_item.kind         = K_STATUS;
        unique case (i_command)
            CMD_WRITE: begin
                o_item.kind   = w_range ? K_STATUS : K_WRITE;
                o_item.status = w_range ? ST_RANGE : ST_DONE;
            end
            CMD_READ: begin
                o_item.kind   = w_range ? K_STATUS : K_READ;
                o_item.status = w_range ? ST_RANGE : ST_DONE;
            end
            CMD_EVENT: begin
                if (w_filtered) begin
                    o_item.status = ST_FILTERED;
                end else if (w_we_c <= w_ws_c) begin
                    o_item.status = ST_EMPTY;
                end else begin
                    o_item.kind = K_EVENT;
                end
            end
            default: begin
                o_item.status = ST_RANGE;
            end
        endcase
    end

endmodule

// ===== src/sawr_fifo.sv =====
// Two-entry queue between the front and back parts.
// Depends on sawr_pkg.
module sawr_fifo import sawr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== src/sawr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the line slope.
// No dependencies.
module sawr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [12:0] i_divisor,
    output logic        o_done,
    output logic [23:0] o_quotient,
    output logic [12:0] o_remainder
);

    logic [23:0] r_quo;
    logic [12:0] r_rem;
    logic [12:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [13:0] w_sh;
    logic        w_ge;

    assign w_sh        = {r_rem, r_quo[23]};
    assign w_ge        = (w_sh >= {1'b0, r_div});
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= 13'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[22:0], w_ge};
            r_rem <= w_ge ? 13'(w_sh - {1'b0, r_div}) : w_sh[12:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/sawr_back.sv =====
// Back part: sample store, write/read execution and window repair sequencer.
// Depends on sawr_pkg and sawr_div.
module sawr_back import sawr_pkg::*; #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_SAMPLES  = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_item              i_head,
    input  logic               i_empty,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [23:0] o_read_value,
    output logic [1:0]         o_status,
    output t_back_stat         o_stat
);

    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW  = $clog2(MAX_SAMPLES);
    localparam int AW  = CHW + SW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_RDA    = 4'd2;
    localparam logic [3:0] S_RDB    = 4'd3;
    localparam logic [3:0] S_CAPA   = 4'd4;
    localparam logic [3:0] S_CAPB   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_FILL   = 4'd7;
    localparam logic [3:0] S_ZERO   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic signed [23:0] r_store [2**AW];
    logic signed [23:0] r_rdata;

    logic [3:0]         r_state, n_state;
    logic [4:0]         r_ch, n_ch;
    logic [12:0]        r_pos, n_pos;
    logic signed [23:0] r_a, n_a;
    logic               r_dneg, n_dneg;
    logic signed [24:0] r_q, n_q;
    logic [12:0]        r_r, n_r;
    logic signed [24:0] r_qd, n_qd;
    logic [12:0]        r_rd, n_rd;
    logic               r_out_valid, n_out_valid;
    logic signed [23:0] r_out_val, n_out_val;
    logic [1:0]         r_out_st, n_out_st;

    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic signed [23:0] w_wdata;
    logic               w_slot;
    logic               w_pop;
    logic               w_load;
    logic               w_div_start;
    logic               w_div_done;
    logic [23:0]        w_div_q;
    logic [12:0]        w_div_r;
    logic signed [24:0] w_d;
    logic [23:0]        w_dmag;
    logic [12:0]        w_den;
    logic [13:0]        w_rsum;
    logic [13:0]        w_two_r;
    logic               w_inc;
    logic               w_wrap;
    logic [4:0]         w_ch_next;

    sawr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dmag),
        .i_divisor   (w_den),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_val;
    assign o_status     = r_out_st;
    assign o_stat.pop      = w_pop;
    assign o_stat.res_load = w_load;
    assign o_stat.busy     = (r_state != S_IDLE);

    always_comb begin
        w_slot    = !r_out_valid || i_out_ready;
        w_den     = i_head.win_end - i_head.win_start;
        w_d       = 25'(r_rdata) - 25'(r_a);
        w_dmag    = w_d[24] ? 24'(-w_d) : w_d[23:0];
        w_rsum    = {1'b0, r_r} + {1'b0, r_rd};
        w_wrap    = (w_rsum >= {1'b0, w_den});
        w_two_r   = {r_r, 1'b0};
        w_inc     = r_q[24] ? (w_two_r > {1'b0, w_den}) : (w_two_r >= {1'b0, w_den});
        w_ch_next = r_ch + 5'd1;

        n_state     = r_state;
        n_ch        = r_ch;
        n_pos       = r_pos;
        n_a         = r_a;
        n_dneg      = r_dneg;
        n_q         = r_q;
        n_r         = r_r;
        n_qd        = r_qd;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_val   = r_out_val;
        n_out_st    = r_out_st;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = {CHW'(r_ch), SW'(r_pos)};
        w_raddr     = {CHW'(r_ch), SW'(i_head.win_start)};
        w_wdata     = 24'sd0;
        w_pop       = 1'b0;
        w_load      = 1'b0;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    case (i_head.kind)
                        K_WRITE: begin
                            if (w_slot) begin
                                w_we    = 1'b1;
                                w_waddr = {CHW'(i_head.channel), SW'(i_head.sample_index)};
                                w_wdata = i_head.sample_value;
                                w_load  = 1'b1;
                                w_pop   = 1'b1;
                                n_out_val = 24'sd0;
                                n_out_st  = ST_DONE;
                            end
                        end
                        K_READ: begin
                            w_re    = 1'b1;
                            w_raddr = {CHW'(i_head.channel), SW'(i_head.sample_index)};
                            n_state = S_RDWAIT;
                        end
                        K_EVENT: begin
                            n_ch    = 5'd0;
                            n_pos   = i_head.win_start;
                            n_state = i_cfg.repair_mode ? S_ZERO : S_RDA;
                        end
                        default: begin
                            if (w_slot) begin
                                w_load    = 1'b1;
                                w_pop     = 1'b1;
                                n_out_val = 24'sd0;
                                n_out_st  = i_head.status;
                            end
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_pop     = 1'b1;
                    n_out_val = r_rdata;
                    n_out_st  = ST_DONE;
                    n_state   = S_IDLE;
                end
            end
            S_RDA: begin
                w_re    = 1'b1;
                n_state = S_RDB;
            end
            S_RDB: begin
                w_re    = 1'b1;
                w_raddr = {CHW'(r_ch), SW'(i_head.win_end)};
                n_a     = r_rdata;
                n_state = S_CAPA;
            end
            S_CAPA: begin
                n_state = S_CAPB;
            end
            S_CAPB: begin
                w_div_start = 1'b1;
                n_dneg      = w_d[24];
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_dneg && (w_div_r != 13'd0)) begin
                        n_qd = -$signed({1'b0, w_div_q}) - 25'sd1;
                        n_rd = w_den - w_div_r;
                    end else if (r_dneg) begin
                        n_qd = -$signed({1'b0, w_div_q});
                        n_rd = 13'd0;
                    end else begin
                        n_qd = $signed({1'b0, w_div_q});
                        n_rd = w_div_r;
                    end
                    n_q     = 25'(r_a);
                    n_r     = 13'd0;
                    n_pos   = i_head.win_start;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_wdata = 24'(r_q + (w_inc ? 25'sd1 : 25'sd0));
                n_q     = r_q + r_qd + (w_wrap ? 25'sd1 : 25'sd0);
                n_r     = w_wrap ? 13'(w_rsum - {1'b0, w_den}) : w_rsum[12:0];
                n_pos   = r_pos + 13'd1;
                if (r_pos == i_head.win_end) begin
                    if (w_ch_next == i_cfg.channels) begin
                        n_state = S_DONE;
                    end else begin
                        n_ch    = w_ch_next;
                        n_state = S_RDA;
                    end
                end
            end
            S_ZERO: begin
                w_we  = 1'b1;
                n_pos = r_pos + 13'd1;
                if (r_pos == i_head.win_end) begin
                    n_pos = i_head.win_start;
                    if (w_ch_next == i_cfg.channels) begin
                        n_state = S_DONE;
                    end else begin
                        n_ch = w_ch_next;
                    end
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_pop     = 1'b1;
                    n_out_val = 24'sd0;
                    n_out_st  = ST_DONE;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_store[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_a       <= n_a;
        r_dneg    <= n_dneg;
        r_q       <= n_q;
        r_r       <= n_r;
        r_qd      <= n_qd;
        r_rd      <= n_rd;
        r_out_val <= n_out_val;
        r_out_st  <= n_out_st;
        r_ch      <= n_ch;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/stim_artifact_window_repair_core.sv =====
// Each command passes through the two-entry queue before its result is loaded into the output register.
// Reads go through a registered store read; results wait while the output is stalled.
// A zeroing event writes zeros over the window on each channel; an interpolating event
// reads both window ends and runs the slope divider once per channel.
// Synchronous active-low reset clears control state and configuration; the
// sample store is not cleared and needs no clearing pass.
`include "stim_artifact_window_repair_core_assert.svh"
module stim_artifact_window_repair_core import sawr_pkg::*; #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_SAMPLES  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // channel[3:0], sample_index[15:4], sample_value[39:16],
    // event_position[55:40], event_code[71:56]
    input  logic [71:0] i_s_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_value[23:0]
    output logic [23:0] o_m_tdata,
    // status[1:0]
    output logic [1:0]  o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_item       w_item;
    t_item       w_head;
    logic        w_push;
    logic        w_full;
    logic        w_empty;
    t_back_stat  w_stat;
    logic signed [23:0] w_read_value;
    logic [4:0]  w_ch_val;
    logic [12:0] w_sm_val;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_full;
    assign w_push      = i_s_tvalid && !w_full;
    assign o_m_tdata   = w_read_value;

    always_comb begin
        w_ch_val = i_cfg_data[4:0];
        if (w_ch_val == 5'd0) begin
            w_ch_val = 5'd1;
        end else if (32'(i_cfg_data[4:0]) > MAX_CHANNELS) begin
            w_ch_val = 5'(MAX_CHANNELS);
        end
        w_sm_val = i_cfg_data[12:0];
        if (w_sm_val == 13'd0) begin
            w_sm_val = 13'd1;
        end else if (32'(i_cfg_data[12:0]) > MAX_SAMPLES) begin
            w_sm_val = 13'(MAX_SAMPLES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_offset <= 14'sd0;
            r_cfg.end_offset   <= 14'sd0;
            r_cfg.code_filter  <= -17'sd1;
            r_cfg.repair_mode  <= 1'b0;
            r_cfg.channels     <= (MAX_CHANNELS < 16) ? 5'(MAX_CHANNELS) : 5'd16;
            r_cfg.samples      <= (MAX_SAMPLES < 4096) ? 13'(MAX_SAMPLES) : 13'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_OFFSET: r_cfg.start_offset <= i_cfg_data[13:0];
                REG_END_OFFSET:   r_cfg.end_offset   <= i_cfg_data[13:0];
                REG_CODE_FILTER:  r_cfg.code_filter  <= i_cfg_data;
                REG_REPAIR_MODE:  r_cfg.repair_mode  <= i_cfg_data[0];
                REG_CHANNELS:     r_cfg.channels     <= w_ch_val;
                REG_SAMPLES:      r_cfg.samples      <= w_sm_val;
                default: begin
                end
            endcase
        end
    end

    sawr_front u_front (
        .i_command        (i_s_tuser),
        .i_channel        (i_s_tdata[3:0]),
        .i_sample_index   (i_s_tdata[15:4]),
        .i_sample_value   (i_s_tdata[39:16]),
        .i_event_position (i_s_tdata[55:40]),
        .i_event_code     (i_s_tdata[71:56]),
        .i_cfg            (r_cfg),
        .o_item           (w_item)
    );

    sawr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_stat.pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sawr_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_read_value (w_read_value),
        .o_status     (o_m_tuser),
        .o_stat       (w_stat)
    );

    `SAWR_ASSERT_IMP(a_pop_with_result, w_stat.pop, w_stat.res_load, "queue pop without result")
    `SAWR_ASSERT_IMP(a_pop_nonempty, w_stat.pop, !w_empty, "pop from empty queue")
    `SAWR_ASSERT_NXT(a_result_valid, w_stat.res_load, o_m_tvalid, "loaded result not presented")

endmodule

// ===== tb/tb_stim_artifact_window_repair_core.sv =====
// Testbench for stim_artifact_window_repair_core: a scoreboard class predicts each result
// from its own copy of the sample store; plain tasks drive stream and configuration ports.
// Depends on sawr_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_stim_artifact_window_repair_core;
    import sawr_pkg::*;

    localparam int NUM_CH  = 16;
    localparam int NUM_SMP = 4096;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic signed [23:0] read_value;
        logic [1:0]         status;
    } t_result;

    class repair_scoreboard;
        logic signed [23:0] store [NUM_CH*NUM_SMP];
        bit                 written [NUM_CH*NUM_SMP];
        int                 win_lo;
        int                 win_hi;
        int                 filt;
        bit                 zero_mode;
        int                 chans;
        int                 smps;
        t_result            expected_q[$];
        int                 errors;

        function new();
            win_lo = 0; win_hi = 0; filt = -1; zero_mode = 0;
            chans = NUM_CH; smps = NUM_SMP; errors = 0;
        endfunction

        function int clamp_size(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [16:0] d);
            case (idx)
                REG_START_OFFSET: win_lo = $signed(d[13:0]);
                REG_END_OFFSET:   win_hi = $signed(d[13:0]);
                REG_CODE_FILTER:  filt = $signed(d);
                REG_REPAIR_MODE:  zero_mode = d[0];
                REG_CHANNELS:     chans = clamp_size(d[4:0], NUM_CH);
                REG_SAMPLES:      smps = clamp_size(d[12:0], NUM_SMP);
                default: ;
            endcase
        endfunction

        // Returns 1 if an interpolating event would use an end sample never written.
        function bit event_needs_unwritten(logic [15:0] pos, logic [15:0] code);
            int ws, we;
            if (filt >= 0 && int'(code) != filt) return 0;
            ws = int'(pos) + win_lo;
            we = int'(pos) + win_hi;
            if (ws < 0) ws = 0;
            if (we > smps - 1) we = smps - 1;
            if (we <= ws || zero_mode) return 0;
            for (int c = 0; c < chans; c++)
                if (!written[c*NUM_SMP+ws] || !written[c*NUM_SMP+we]) return 1;
            return 0;
        endfunction

        function logic signed [23:0] line_point(longint a, longint b, longint den, longint s);
            longint num, mag, q;
            num = a*den + s*(b - a);
            mag = num < 0 ? -num : num;
            q = (2*mag + den) / (2*den);
            return num < 0 ? -q : q;
        endfunction

        function logic [1:0] repair(logic [15:0] pos, logic [15:0] code);
            int ws, we, len, base;
            longint a, b;
            if (filt >= 0 && int'(code) != filt) return ST_FILTERED;
            ws = int'(pos) + win_lo;
            we = int'(pos) + win_hi;
            if (ws < 0) ws = 0;
            if (we > smps - 1) we = smps - 1;
            if (we <= ws) return ST_EMPTY;
            len = we - ws + 1;
            for (int c = 0; c < chans; c++) begin
                base = c * NUM_SMP;
                a = store[base+ws];
                b = store[base+we];
                for (int s = 0; s < len; s++) begin
                    store[base+ws+s] = zero_mode ? 24'sd0 : line_point(a, b, len - 1, s);
                    written[base+ws+s] = 1;
                end
            end
            return ST_DONE;
        endfunction

        function void note_input(logic [1:0] cmd, logic [71:0] d);
            t_result r;
            int addr;
            r = '0;
            addr = int'(d[3:0]) * NUM_SMP + int'(d[15:4]);
            if (cmd == CMD_WRITE || cmd == CMD_READ) begin
                if (d[3:0] >= chans || d[15:4] >= smps) begin
                    r.status = ST_RANGE;
                end else if (cmd == CMD_WRITE) begin
                    store[addr] = d[39:16];
                    written[addr] = 1;
                    r.status = ST_DONE;
                end else begin
                    r.read_value = store[addr];
                    r.status = ST_DONE;
                end
            end else if (cmd == CMD_EVENT) begin
                r.status = repair(d[55:40], d[71:56]);
            end else begin
                r.status = ST_RANGE;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [23:0] rv, logic [1:0] st);
            t_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result: read_value %0h status %0d", rv, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (rv !== e.read_value) begin
                $error("read_value: expected %0h, actual %0h", e.read_value, rv);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    repair_scoreboard sb = new();
    bit idle_on = 1;
    int stall_cycles = 0;

    stim_artifact_window_repair_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
            i_m_tready <= idle_on ? ($urandom % 100 >= 18) : 1'b1;
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [71:0] d);
        while (idle_on && $urandom % 100 < 18) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= cmd;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(cmd, d);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    function automatic logic [71:0] pack(int ch, int idx, int val, int pos, int code);
        return {code[15:0], pos[15:0], val[23:0], idx[11:0], ch[3:0]};
    endfunction

    task automatic configure(int lo, int hi, int filt, int mode, int ch, int smp);
        drain();
        write_reg(REG_START_OFFSET, 17'(lo));
        write_reg(REG_END_OFFSET, 17'(hi));
        write_reg(REG_CODE_FILTER, 17'(filt));
        write_reg(REG_REPAIR_MODE, 17'(mode));
        write_reg(REG_CHANNELS, 17'(ch));
        write_reg(REG_SAMPLES, 17'(smp));
    endtask

    task automatic fill(int span);
        for (int c = 0; c < sb.chans; c++)
            for (int s = 0; s < span; s++)
                send_item(CMD_WRITE, pack(c, s, $urandom, $urandom, $urandom));
    endtask

    task automatic random_items(int count, int span);
        logic [71:0] d;
        logic [1:0]  cmd;
        int          r, ch, idx, pos, code;
        for (int n = 0; n < count; n++) begin
            r = $urandom % 100;
            ch = ($urandom % 10 == 0) ? $urandom_range(0, 15) : $urandom_range(0, sb.chans - 1);
            idx = ($urandom % 10 == 0) ? $urandom_range(0, 4095) : $urandom_range(0, span - 1);
            pos = ($urandom % 20 == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span + 8);
            code = (sb.filt >= 0 && $urandom % 2) ? sb.filt : $urandom_range(0, 65535);
            d = {code[15:0], pos[15:0], 24'($urandom), idx[11:0], ch[3:0]};
            if (r < 35) cmd = CMD_WRITE;
            else if (r < 60) cmd = CMD_READ;
            else if (r < 95) cmd = CMD_EVENT;
            else cmd = 2'd3;
            if (cmd == CMD_READ && ch < sb.chans && idx < sb.smps
                    && !sb.written[ch*NUM_SMP+idx])
                cmd = CMD_WRITE;
            if (cmd == CMD_EVENT && sb.event_needs_unwritten(pos[15:0], code[15:0]))
                cmd = CMD_WRITE;
            send_item(cmd, d);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_item(CMD_WRITE, pack(0, 0, 32'h7FFFFF, 0, 0));
        send_item(CMD_WRITE, pack(15, 4095, 32'h800000, 65535, 65535));
        send_item(CMD_WRITE, pack(7, 2048, -1, 0, 0));
        send_item(CMD_READ, pack(0, 0, 0, 0, 0));
        send_item(CMD_READ, pack(15, 4095, 0, 0, 0));
        send_item(CMD_READ, pack(7, 2048, 0, 0, 0));
        send_item(2'd3, pack(15, 4095, -1, 65535, 65535));
        send_item(CMD_EVENT, pack(0, 0, 0, 100, 0));
        send_item(CMD_EVENT, pack(0, 0, 0, 65535, 65535));

        configure(-2, 3, -1, 0, 4, 24);
        send_item(CMD_WRITE, pack(15, 0, 5, 0, 0));
        send_item(CMD_READ, pack(0, 4095, 0, 0, 0));
        fill(24);
        random_items(100, 24);

        configure(-8192, 8191, 65535, 1, 0, 16);
        fill(16);
        send_item(CMD_EVENT, pack(0, 0, 0, 3, 65535));
        send_item(CMD_EVENT, pack(0, 0, 0, 3, 0));
        random_items(120, 16);

        idle_on = 0;
        configure(-1, 4, 5, 0, 16, 12);
        fill(12);
        random_items(80, 12);
        idle_on = 1;

        configure(-4, 2, -1, 0, 2, 8191);
        write_reg(3'd7, 17'h1FFFF);
        fill(40);
        random_items(150, 40);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/sawr_pkg.sv
src/sawr_front.sv
src/sawr_fifo.sv
src/sawr_div.sv
src/sawr_back.sv
src/stim_artifact_window_repair_core.sv
tb/tb_stim_artifact_window_repair_core.sv
